// File: design/nfha_pkg.sv
// Shared types and constants of the next-fit heap allocator.
// Used by the allocator, its sequencer and the tests; depends on nothing.
package nfha_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 9;
    localparam int ADDR_W       = 12;   // payload address, header store index
    localparam int OFF_W        = 13;   // header offsets, heap top, sizes
    localparam int SUM_W        = 14;   // offset plus size plus header
    localparam int MEM_W        = 14;   // payload size and used flag
    localparam int STEP_W       = 13;   // walk step count, reaches HEAP_BYTES
    localparam int UPC_W        = 5;    // microcode step counter

    // Stream beat widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Datapath actions, one per microcode step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_RD_P,
        OP_STEP,
        OP_GROW,
        OP_SPLIT_WR,
        OP_TAKE,
        OP_RD_FREE,
        OP_CLR_FREE,
        OP_RES_OK,
        OP_RES_NULL,
        OP_RES_FULL
    } t_op;

    // Status from the datapath that the sequencer branches or waits on.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic is_alloc;
        logic is_free;
        logic is_unused;
        logic p_at_top;
        logic fit;
        logic walk_more;
        logic no_split;
        logic grow_fail;
        logic addr_null;
        logic addr_low;
    } t_flags;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctl;

endpackage

// File: design/next_fit_heap_allocator.sv
// Next-fit heap allocator over a heap of nfha_pkg::HEAP_BYTES bytes with
// 9-byte block headers: each beat allocates, frees, restarts or, in the
// unused mode, does nothing, and gives one result beat. The block takes
// one item at a time. Its program runs from a microcode sequencer over a
// header store of one write and one read port. An allocation visits block
// headers one at a time from the rover and takes the first free block that
// fits, split when the tail is large enough, or else grows the heap or finds
// it exhausted, so its time grows with the number of blocks in the heap.
// Each item also waits for the output register when the previous result
// has not yet been taken. There is no clearing pass after reset. Depends
// on nfha_pkg and nfha_seq.
module next_fit_heap_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] mode, [14:2] request_size, [26:15] block_address, rest zero
    input  logic [nfha_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [11:0] payload_address, [13:12] status, rest zero
    output logic [nfha_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam logic [nfha_pkg::SUM_W-1:0] HDR_S =
        nfha_pkg::SUM_W'(nfha_pkg::HEADER_BYTES);
    localparam logic [nfha_pkg::SUM_W-1:0] HEAP_S =
        nfha_pkg::SUM_W'(nfha_pkg::HEAP_BYTES);

    nfha_pkg::t_ctl   ctl;
    nfha_pkg::t_flags flags;

    // Latched item.
    nfha_pkg::t_mode                r_mode;
    logic [nfha_pkg::OFF_W-1:0]     r_req;
    logic [nfha_pkg::ADDR_W-1:0]    r_addr;

    // Allocator state and walk registers.
    logic [nfha_pkg::OFF_W-1:0]     r_rover;
    logic [nfha_pkg::OFF_W-1:0]     r_top;
    logic [nfha_pkg::OFF_W-1:0]     r_p;
    logic [nfha_pkg::STEP_W-1:0]    r_steps;

    // Header store and its registered read data.
    logic [nfha_pkg::MEM_W-1:0]     mem [nfha_pkg::HEAP_BYTES];
    logic [nfha_pkg::MEM_W-1:0]     r_rd;
    logic                           mem_we;
    logic                           mem_re;
    logic [nfha_pkg::ADDR_W-1:0]    mem_wa;
    logic [nfha_pkg::ADDR_W-1:0]    mem_ra;
    logic [nfha_pkg::MEM_W-1:0]     mem_wd;

    // Result register.
    logic                           r_out_valid;
    logic [nfha_pkg::ADDR_W-1:0]    r_out_addr;
    nfha_pkg::t_status              r_out_status;

    // Datapath arithmetic.
    logic                           rd_used;
    logic [nfha_pkg::OFF_W-1:0]     rd_size;
    logic [nfha_pkg::SUM_W-1:0]     sum_next;
    logic [nfha_pkg::OFF_W-1:0]     p_next;
    logic [nfha_pkg::SUM_W-1:0]     req_hdr;
    logic [nfha_pkg::SUM_W-1:0]     tail_off;
    logic                           split;
    logic [nfha_pkg::OFF_W-1:0]     take_size;
    logic [nfha_pkg::SUM_W-1:0]     top_hdr;
    logic [nfha_pkg::SUM_W-1:0]     top_end;
    logic [nfha_pkg::ADDR_W-1:0]    free_off;
    logic                           out_take;
    logic                           res_load;

    nfha_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    // Header fields, chain step and split/grow arithmetic.
    assign rd_used   = r_rd[0];
    assign rd_size   = r_rd[nfha_pkg::MEM_W-1:1];
    assign sum_next  = {1'b0, r_p} + {1'b0, rd_size} + HDR_S;
    assign p_next    = (sum_next >= {1'b0, r_top}) ? '0
                                                   : sum_next[nfha_pkg::OFF_W-1:0];
    assign req_hdr   = {1'b0, r_req} + HDR_S;
    assign tail_off  = {1'b0, r_p} + req_hdr;
    assign split     = {1'b0, rd_size} > req_hdr;
    assign take_size = split ? r_req : rd_size;
    assign top_hdr   = {1'b0, r_top} + HDR_S;
    assign top_end   = top_hdr + {1'b0, r_req};
    assign free_off  = r_addr - nfha_pkg::ADDR_W'(nfha_pkg::HEADER_BYTES);
    assign out_take  = r_out_valid && i_m_tready;
    assign res_load  = (ctl.op == nfha_pkg::OP_GROW) ||
                       (ctl.op == nfha_pkg::OP_TAKE) ||
                       (ctl.op == nfha_pkg::OP_RES_OK) ||
                       (ctl.op == nfha_pkg::OP_RES_NULL) ||
                       (ctl.op == nfha_pkg::OP_RES_FULL);

    // Flags for the sequencer.
    assign flags.in_valid  = i_s_tvalid;
    assign flags.out_busy  = r_out_valid && !i_m_tready;
    assign flags.is_alloc  = (r_mode == nfha_pkg::MODE_ALLOC);
    assign flags.is_free   = (r_mode == nfha_pkg::MODE_FREE);
    assign flags.is_unused = (r_mode == nfha_pkg::MODE_UNUSED);
    assign flags.p_at_top  = (r_p == r_top);
    assign flags.fit       = !rd_used && (rd_size >= r_req);
    assign flags.walk_more = (r_p != r_rover) &&
                             (r_steps < nfha_pkg::STEP_W'(nfha_pkg::HEAP_BYTES));
    assign flags.no_split  = !split;
    assign flags.grow_fail = (top_hdr >= HEAP_S) || (top_end > HEAP_S);
    assign flags.addr_null = (r_addr == '0);
    assign flags.addr_low  = (r_addr < nfha_pkg::ADDR_W'(nfha_pkg::HEADER_BYTES));

    // Header store port control.
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = r_p[nfha_pkg::ADDR_W-1:0];
        mem_ra = r_p[nfha_pkg::ADDR_W-1:0];
        mem_wd = {take_size, 1'b1};
        case (ctl.op)
            nfha_pkg::OP_RD_P: begin
                mem_re = 1'b1;
            end
            nfha_pkg::OP_RD_FREE: begin
                mem_re = 1'b1;
                mem_ra = free_off;
            end
            nfha_pkg::OP_CLR_FREE: begin
                mem_we = 1'b1;
                mem_wa = free_off;
                mem_wd = {rd_size, 1'b0};
            end
            nfha_pkg::OP_SPLIT_WR: begin
                // The tail keeps what is left after the request and its header.
                mem_we = 1'b1;
                mem_wa = tail_off[nfha_pkg::ADDR_W-1:0];
                mem_wd = {rd_size - req_hdr[nfha_pkg::OFF_W-1:0], 1'b0};
            end
            nfha_pkg::OP_TAKE: begin
                mem_we = 1'b1;
            end
            nfha_pkg::OP_GROW: begin
                mem_we = 1'b1;
                mem_wa = r_top[nfha_pkg::ADDR_W-1:0];
                mem_wd = {r_req, 1'b1};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // Control state: rover, heap top and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover     <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (ctl.op)
                nfha_pkg::OP_RESTART: begin
                    r_rover <= '0;
                    r_top   <= '0;
                end
                nfha_pkg::OP_GROW: begin
                    r_rover <= r_top;
                    r_top   <= top_end[nfha_pkg::OFF_W-1:0];
                end
                nfha_pkg::OP_TAKE: begin
                    r_rover <= r_p;
                end
                default: begin
                    r_rover <= r_rover;
                end
            endcase
        end
    end

    // Item latch, walk registers and result payload.
    always_ff @(posedge i_clk) begin
        case (ctl.op)
            nfha_pkg::OP_LOAD: begin
                r_mode  <= nfha_pkg::t_mode'(i_s_tdata[1:0]);
                r_req   <= i_s_tdata[14:2];
                r_addr  <= i_s_tdata[26:15];
                r_p     <= r_rover;
                r_steps <= '0;
            end
            nfha_pkg::OP_STEP: begin
                r_p     <= p_next;
                r_steps <= r_steps + nfha_pkg::STEP_W'(1);
            end
            nfha_pkg::OP_GROW: begin
                r_out_addr   <= top_hdr[nfha_pkg::ADDR_W-1:0];
                r_out_status <= nfha_pkg::ST_OK;
            end
            nfha_pkg::OP_TAKE: begin
                r_out_addr   <= r_p[nfha_pkg::ADDR_W-1:0] +
                                nfha_pkg::ADDR_W'(nfha_pkg::HEADER_BYTES);
                r_out_status <= nfha_pkg::ST_OK;
            end
            nfha_pkg::OP_RES_OK: begin
                r_out_addr   <= '0;
                r_out_status <= nfha_pkg::ST_OK;
            end
            nfha_pkg::OP_RES_NULL: begin
                r_out_addr   <= '0;
                r_out_status <= nfha_pkg::ST_NULL;
            end
            nfha_pkg::OP_RES_FULL: begin
                r_out_addr   <= '0;
                r_out_status <= nfha_pkg::ST_FULL;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    // Ports.
    assign o_s_tready = ctl.in_ready && i_rst_n;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_status, r_out_addr};

    // The heap top never passes the heap end.
    a_top_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= nfha_pkg::OFF_W'(nfha_pkg::HEAP_BYTES))
        else $error("heap top beyond heap end");

    // The rover lies below the top unless the heap is empty.
    a_rover_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rover < r_top) || ((r_rover == '0) && (r_top == '0)))
        else $error("rover not below heap top");

    // The walk only reads headers inside the block chain.
    a_walk_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == nfha_pkg::OP_RD_P) |-> (r_p < r_top))
        else $error("walk read beyond heap top");

    // A grown block always fits inside the heap.
    a_grow_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == nfha_pkg::OP_GROW) |-> ((top_hdr < HEAP_S) && (top_end <= HEAP_S)))
        else $error("grown block past heap end");

    // A result is written only when the output register is free or taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> (ctl.op != nfha_pkg::OP_TAKE &&
                                          ctl.op != nfha_pkg::OP_GROW &&
                                          ctl.op != nfha_pkg::OP_RES_OK &&
                                          ctl.op != nfha_pkg::OP_RES_NULL &&
                                          ctl.op != nfha_pkg::OP_RES_FULL))
        else $error("result overwritten before it was taken");

endmodule

// File: design/nfha_seq.sv
// Microcode sequencer of the next-fit heap allocator: control store,
// step counter and branch logic. Depends on nfha_pkg.
module nfha_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nfha_pkg::t_flags i_flags,
    output nfha_pkg::t_ctl   o_ctl
);

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_ALLOC,
        C_IS_FREE,
        C_IS_UNUSED,
        C_P_AT_TOP,
        C_FIT,
        C_WALK_MORE,
        C_NO_SPLIT,
        C_GROW_FAIL,
        C_ADDR_NULL,
        C_ADDR_LOW
    } t_cond;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_stall;

    typedef struct packed {
        nfha_pkg::t_op  op;
        t_stall         stall;
        t_cond          cond;
        nfha_pkg::t_upc target;
    } t_uword;

    // Entry points of the microprogram.
    localparam nfha_pkg::t_upc UA_IDLE   = 5'd0;
    localparam nfha_pkg::t_upc UA_RES_OK = 5'd5;
    localparam nfha_pkg::t_upc UA_WALK   = 5'd6;
    localparam nfha_pkg::t_upc UA_READ   = 5'd7;
    localparam nfha_pkg::t_upc UA_GROW   = 5'd11;
    localparam nfha_pkg::t_upc UA_FOUND  = 5'd13;
    localparam nfha_pkg::t_upc UA_TAKE   = 5'd15;
    localparam nfha_pkg::t_upc UA_FULL   = 5'd16;
    localparam nfha_pkg::t_upc UA_FREE   = 5'd17;
    localparam nfha_pkg::t_upc UA_NULL   = 5'd21;

    function automatic t_uword mk(nfha_pkg::t_op op, t_stall st, t_cond c,
                                  nfha_pkg::t_upc tgt);
        t_uword w;
        w.op     = op;
        w.stall  = st;
        w.cond   = c;
        w.target = tgt;
        return w;
    endfunction

    // Control store. A taken condition jumps to target, else the next step.
    function automatic t_uword ucode(nfha_pkg::t_upc a);
        t_uword w;
        case (a)
            // Wait for an input beat, latch it, then dispatch on mode.
            5'd0:  w = mk(nfha_pkg::OP_LOAD, W_IN, C_NEVER, UA_IDLE);
            5'd1:  w = mk(nfha_pkg::OP_NONE, W_NONE, C_IS_ALLOC, UA_WALK);
            5'd2:  w = mk(nfha_pkg::OP_NONE, W_NONE, C_IS_FREE, UA_FREE);
            5'd3:  w = mk(nfha_pkg::OP_NONE, W_NONE, C_IS_UNUSED, UA_RES_OK);
            5'd4:  w = mk(nfha_pkg::OP_RESTART, W_NONE, C_NEVER, UA_IDLE);
            5'd5:  w = mk(nfha_pkg::OP_RES_OK, W_OUT, C_ALWAYS, UA_IDLE);
            // Next-fit walk from the rover.
            5'd6:  w = mk(nfha_pkg::OP_NONE, W_NONE, C_P_AT_TOP, UA_GROW);
            5'd7:  w = mk(nfha_pkg::OP_RD_P, W_NONE, C_NEVER, UA_IDLE);
            5'd8:  w = mk(nfha_pkg::OP_NONE, W_NONE, C_FIT, UA_FOUND);
            5'd9:  w = mk(nfha_pkg::OP_STEP, W_NONE, C_NEVER, UA_IDLE);
            5'd10: w = mk(nfha_pkg::OP_NONE, W_NONE, C_WALK_MORE, UA_READ);
            // No free block fits: append one at the heap top or report full.
            5'd11: w = mk(nfha_pkg::OP_NONE, W_NONE, C_GROW_FAIL, UA_FULL);
            5'd12: w = mk(nfha_pkg::OP_GROW, W_OUT, C_ALWAYS, UA_IDLE);
            // A free block fits: split off the tail if it is big enough.
            5'd13: w = mk(nfha_pkg::OP_NONE, W_NONE, C_NO_SPLIT, UA_TAKE);
            5'd14: w = mk(nfha_pkg::OP_SPLIT_WR, W_NONE, C_NEVER, UA_IDLE);
            5'd15: w = mk(nfha_pkg::OP_TAKE, W_OUT, C_ALWAYS, UA_IDLE);
            5'd16: w = mk(nfha_pkg::OP_RES_FULL, W_OUT, C_ALWAYS, UA_IDLE);
            // Free: skip null and low addresses, read the header, clear its flag.
            5'd17: w = mk(nfha_pkg::OP_NONE, W_NONE, C_ADDR_NULL, UA_NULL);
            5'd18: w = mk(nfha_pkg::OP_NONE, W_NONE, C_ADDR_LOW, UA_RES_OK);
            5'd19: w = mk(nfha_pkg::OP_RD_FREE, W_NONE, C_NEVER, UA_IDLE);
            5'd20: w = mk(nfha_pkg::OP_CLR_FREE, W_NONE, C_ALWAYS, UA_RES_OK);
            5'd21: w = mk(nfha_pkg::OP_RES_NULL, W_OUT, C_ALWAYS, UA_IDLE);
            default: w = mk(nfha_pkg::OP_NONE, W_NONE, C_ALWAYS, UA_IDLE);
        endcase
        return w;
    endfunction

    nfha_pkg::t_upc r_upc;
    nfha_pkg::t_upc n_upc;
    t_uword         word;
    logic           stalled;
    logic           taken;

    assign word = ucode(r_upc);

    // A step holds while it waits for an input beat or a free output register.
    always_comb begin
        case (word.stall)
            W_IN:    stalled = !i_flags.in_valid;
            W_OUT:   stalled = i_flags.out_busy;
            default: stalled = 1'b0;
        endcase
    end

    // Branch condition select.
    always_comb begin
        case (word.cond)
            C_ALWAYS:    taken = 1'b1;
            C_IS_ALLOC:  taken = i_flags.is_alloc;
            C_IS_FREE:   taken = i_flags.is_free;
            C_IS_UNUSED: taken = i_flags.is_unused;
            C_P_AT_TOP:  taken = i_flags.p_at_top;
            C_FIT:       taken = i_flags.fit;
            C_WALK_MORE: taken = i_flags.walk_more;
            C_NO_SPLIT:  taken = i_flags.no_split;
            C_GROW_FAIL: taken = i_flags.grow_fail;
            C_ADDR_NULL: taken = i_flags.addr_null;
            C_ADDR_LOW:  taken = i_flags.addr_low;
            default:     taken = 1'b0;
        endcase
    end

    always_comb begin
        if (stalled) begin
            n_upc = r_upc;
        end else if (taken) begin
            n_upc = word.target;
        end else begin
            n_upc = r_upc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // The datapath acts only on steps that are not held.
    assign o_ctl.op       = stalled ? nfha_pkg::OP_NONE : word.op;
    assign o_ctl.in_ready = (word.stall == W_IN);

endmodule

// File: test/nfha_shadow_pkg.sv
`timescale 1ns / 100ps
// Shadow copy of the next-fit heap allocator that checks its result beats.
// Depends on nfha_pkg for the heap geometry, modes and status codes.
package nfha_shadow_pkg;

    import nfha_pkg::*;

    // One result beat as the allocator should give it.
    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   payload_addr;
    } heap_reply_t;

    class heap_shadow;

        // Mirrored heap: one header entry per byte offset.
        bit          used_flag   [HEAP_BYTES];
        int unsigned block_size  [HEAP_BYTES];
        bit          hdr_written [HEAP_BYTES];
        int unsigned written_offsets[$];
        int unsigned rover;
        int unsigned heap_top;

        // Replies still owed by the allocator, oldest first.
        heap_reply_t awaited_replies[$];
        int unsigned mismatches;
        int unsigned replies_checked;

        function new();
            rover           = 0;
            heap_top        = 0;
            mismatches      = 0;
            replies_checked = 0;
        endfunction

        function void put_header(int unsigned off, bit used, int unsigned blk_size);
            if (off < HEAP_BYTES) begin
                used_flag[off]  = used;
                block_size[off] = blk_size;
                if (!hdr_written[off]) begin
                    hdr_written[off] = 1'b1;
                    written_offsets.push_back(off);
                end
            end
        endfunction

        // Next-fit search from the rover; grows the heap when nothing fits, or reports it full.
        function heap_reply_t predict_alloc(int unsigned req);
            heap_reply_t r;
            int unsigned p;
            int unsigned found_size;
            int unsigned steps;
            bit          found;
            bit          searching;
            r.payload_addr = '0;
            r.status       = ST_OK;
            p              = rover;
            found          = 1'b0;
            steps          = 0;
            if (p != heap_top) begin
                searching = 1'b1;
                while (searching) begin
                    if (!used_flag[p] && block_size[p] >= req) begin
                        found     = 1'b1;
                        searching = 1'b0;
                    end else begin
                        p = p + block_size[p] + HEADER_BYTES;
                        if (p >= heap_top)
                            p = 0;
                        steps++;
                        if (p == rover || steps >= HEAP_BYTES)
                            searching = 1'b0;
                    end
                end
            end
            if (found) begin
                found_size = block_size[p];
                // Split only when the tail would hold more than a bare header.
                if (found_size > req + HEADER_BYTES) begin
                    put_header(p + req + HEADER_BYTES, 1'b0,
                               found_size - req - HEADER_BYTES);
                    put_header(p, 1'b1, req);
                end else begin
                    put_header(p, 1'b1, found_size);
                end
            end else begin
                p = heap_top;
                if (p + HEADER_BYTES >= HEAP_BYTES || p + HEADER_BYTES + req > HEAP_BYTES) begin
                    r.status = ST_FULL;
                    return r;
                end
                heap_top = p + HEADER_BYTES + req;
                put_header(p, 1'b1, req);
            end
            rover          = p;
            r.payload_addr = ADDR_W'(p + HEADER_BYTES);
            return r;
        endfunction

        // Applies one accepted input beat and queues the reply it owes.
        function heap_reply_t note_request(t_mode op_mode, int unsigned req,
                                           int unsigned addr);
            heap_reply_t r;
            r.payload_addr = '0;
            r.status       = ST_OK;
            case (op_mode)
                MODE_ALLOC: begin
                    r = predict_alloc(req);
                end
                MODE_FREE: begin
                    if (addr == 0)
                        r.status = ST_NULL;
                    else if (addr >= HEADER_BYTES && addr - HEADER_BYTES < HEAP_BYTES)
                        used_flag[addr - HEADER_BYTES] = 1'b0;
                end
                MODE_RESTART: begin
                    rover    = 0;
                    heap_top = 0;
                end
                default: ;
            endcase
            awaited_replies.push_back(r);
            return r;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("reply %0d: %s", replies_checked, what);
        endfunction

        // Compares one result beat with the oldest awaited reply.
        function void check_reply(logic [OUT_DATA_W-1:0] beat);
            heap_reply_t exp_reply;
            replies_checked++;
            if (awaited_replies.size() == 0) begin
                report($sformatf("unexpected beat 0x%04h", beat));
                return;
            end
            exp_reply = awaited_replies.pop_front();
            if (beat[ADDR_W-1:0] !== exp_reply.payload_addr)
                report($sformatf("payload_address expected %0d, got %0d",
                                 exp_reply.payload_addr, beat[ADDR_W-1:0]));
            if (beat[ADDR_W+1:ADDR_W] !== exp_reply.status)
                report($sformatf("status expected %0d, got %0d",
                                 exp_reply.status, beat[ADDR_W+1:ADDR_W]));
        endfunction

    endclass

endpackage

// File: test/tb_next_fit_heap_allocator.sv
`timescale 1ns / 100ps
// Stream-level regression of next_fit_heap_allocator: directed corner cases,
// then random allocate/free/restart episodes. Depends on nfha_pkg and nfha_shadow_pkg.
module tb_next_fit_heap_allocator;

    import nfha_pkg::*;
    import nfha_shadow_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned CYCLE_LIMIT  = 12_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 600;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    heap_shadow             shadow;
    logic [ADDR_W-1:0]      live_blocks[$];
    int unsigned            items_sent   = 0;
    int unsigned            replies_seen = 0;
    int unsigned            cycle_count  = 0;
    int unsigned            burst_left   = 0;
    bit                     gapless      = 1'b0;
    bit                     valid_high   = 1'b0;

    // Receiver stall state.
    int unsigned            hold_left    = 0;
    bit                     hold_done    = 1'b0;
    int unsigned            phase_left   = 0;
    int unsigned            stall_style  = 0;
    int unsigned            pattern_pos  = 0;

    next_fit_heap_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            shadow.check_reply(o_m_tdata);
            replies_seen++;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (replies_seen == HOLD_AT && !hold_done) begin
            // One long back-pressure stretch so the allocator backs up its input.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_style = $urandom_range(0, 3);
                phase_left  = $urandom_range(50, 300);
            end
            phase_left--;
            pattern_pos = (pattern_pos + 1) % 7;
            case (stall_style)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom_range(0, 1));
                2: i_m_tready <= (pattern_pos >= 3);
                default: i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offers one input beat, waits for it to be taken and records it.
    task automatic send_beat(input t_mode op_mode, input logic [OFF_W-1:0] req,
                             input logic [ADDR_W-1:0] addr);
        heap_reply_t reply;
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        valid_high = 1'b1;
        i_s_tdata  <= {5'd0, addr, req, op_mode};
        do @(posedge i_clk); while (!o_s_tready);
        reply = shadow.note_request(op_mode, 32'(req), 32'(addr));
        items_sent++;
        if (op_mode == MODE_ALLOC && reply.status == ST_OK)
            live_blocks.push_back(reply.payload_addr);
        if (op_mode == MODE_RESTART)
            live_blocks.delete();
        // Bursts of back-to-back beats separated by idle gaps, unless gapless is set.
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!gapless) begin
                gap = $urandom_range(1, 10);
                i_s_tvalid <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // One stretch of random traffic closed by a restart.
    task automatic run_episode(input int unsigned n_items, input int unsigned size_kind);
        int unsigned pick;
        int unsigned req;
        int unsigned idx;
        int unsigned off;
        logic [ADDR_W-1:0] addr;
        for (int unsigned k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case (size_kind)
                    0: req = $urandom_range(0, 15);
                    1: req = $urandom_range(0, 300);
                    2: req = $urandom_range(150, 1500);
                    default: req = $urandom_range(0, 60);
                endcase
                if ($urandom_range(0, 31) == 0)
                    req = $urandom_range(0, 8191);
                send_beat(MODE_ALLOC, OFF_W'(req), ADDR_W'($urandom_range(0, 4095)));
            end else if (pick < 85 && live_blocks.size() != 0) begin
                idx  = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[idx];
                live_blocks.delete(idx);
                send_beat(MODE_FREE, OFF_W'($urandom_range(0, 8191)), addr);
            end else if (pick < 91) begin
                // Any header ever written, stale ones inside payloads included.
                off = shadow.written_offsets[$urandom_range(0,
                                              shadow.written_offsets.size() - 1)];
                send_beat(MODE_FREE, OFF_W'($urandom_range(0, 8191)),
                          ADDR_W'(off + HEADER_BYTES));
            end else if (pick < 94) begin
                send_beat(MODE_FREE, OFF_W'($urandom_range(0, 8191)), '0);
            end else if (pick < 97) begin
                send_beat(MODE_FREE, OFF_W'($urandom_range(0, 8191)),
                          ADDR_W'($urandom_range(1, HEADER_BYTES - 1)));
            end else begin
                send_beat(MODE_UNUSED, OFF_W'($urandom_range(0, 8191)),
                          ADDR_W'($urandom_range(0, 4095)));
            end
        end
        send_beat(MODE_RESTART, OFF_W'($urandom_range(0, 8191)),
                  ADDR_W'($urandom_range(0, 4095)));
    endtask

    initial begin
        int unsigned random_target;
        shadow = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases.
        send_beat(MODE_FREE,    13'h1FFF, 12'd0);       // free of null
        send_beat(MODE_FREE,    13'd0,    12'd8);       // address below first payload
        send_beat(MODE_UNUSED,  13'h1FFF, 12'hFFF);
        send_beat(MODE_ALLOC,   13'd0,    12'd0);       // empty heap grows
        send_beat(MODE_ALLOC,   13'h1FFF, 12'd0);       // far too large
        send_beat(MODE_ALLOC,   13'd100,  12'd0);
        send_beat(MODE_FREE,    13'd0,    12'd18);
        send_beat(MODE_ALLOC,   13'd50,   12'd0);       // split of a freed block
        send_beat(MODE_ALLOC,   13'd41,   12'd0);       // exact fit of the tail
        send_beat(MODE_FREE,    13'd0,    12'd77);
        send_beat(MODE_ALLOC,   13'd32,   12'd0);       // remainder of a bare header: no split
        send_beat(MODE_FREE,    13'd0,    12'd77);
        send_beat(MODE_ALLOC,   13'd31,   12'd0);       // split leaving a one-byte tail
        send_beat(MODE_ALLOC,   13'd500,  12'd0);       // walk wraps, then grows
        send_beat(MODE_RESTART, 13'd0,    12'd0);
        send_beat(MODE_ALLOC,   13'd200,  12'd0);
        send_beat(MODE_FREE,    13'd0,    12'd18);      // stale header inside a payload
        send_beat(MODE_ALLOC,   13'd10,   12'd0);
        send_beat(MODE_ALLOC,   13'd3859, 12'd0);       // ends exactly at the heap end
        send_beat(MODE_ALLOC,   13'd4096, 12'd0);       // heap exhausted
        send_beat(MODE_RESTART, 13'd0,    12'd0);
        send_beat(MODE_ALLOC,   13'd4077, 12'd0);
        send_beat(MODE_ALLOC,   13'd0,    12'd0);       // highest payload address
        send_beat(MODE_ALLOC,   13'd0,    12'd0);       // header would not fit
        send_beat(MODE_FREE,    13'd0,    12'hFFF);
        send_beat(MODE_RESTART, 13'd0,    12'd0);

        // Random episodes of mixed block sizes.
        random_target = items_sent + RANDOM_ITEMS;
        while (items_sent < random_target) begin
            gapless = ($urandom_range(0, 3) == 0);
            run_episode($urandom_range(20, 110), $urandom_range(0, 3));
        end
        if (valid_high)
            i_s_tvalid <= 1'b0;

        // Drain the owed replies, then allow for stray beats.
        while (shadow.awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.awaited_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
